>>> rtl/pfd_pkg.sv
// shared types and codes for the per-source flood detector
package pfd_pkg;

  localparam logic [1:0] REQ_MSG    = 2'd0;
  localparam logic [1:0] REQ_SWEEP  = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam logic [1:0] CFG_TRIGGER = 2'd0;
  localparam logic [1:0] CFG_BURST   = 2'd1;
  localparam logic [1:0] CFG_IDLE    = 2'd2;

  localparam logic [7:0] TRIGGER_RST = 8'd5;
  localparam logic [7:0] BURST_RST   = 8'd1;
  localparam logic [7:0] IDLE_RST    = 8'd3;
  localparam logic [7:0] LEVEL_MAX   = 8'd255;

  typedef struct packed {
    logic [7:0] trigger;
    logic [7:0] burst;
    logic [7:0] idle;
  } pfd_cfg_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  req;
    logic [31:0] key;
    logic [31:0] now;
    logic        hit;
    logic        free_seen;
    logic        flood;
    logic [7:0]  level;
  } pfd_tok_t;

  typedef struct packed {
    logic        en;
    logic [31:0] key;
    logic [31:0] now;
  } pfd_ins_t;

endpackage

>>> rtl/pfd_cell.sv
// one table entry with its stage of the request chain
module pfd_cell
  import pfd_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] slot_idx,
  input  pfd_cfg_t         cfg,
  input  pfd_ins_t         ins,
  input  logic [IDX_W-1:0] ins_idx,
  input  pfd_tok_t         tok_in,
  input  logic [IDX_W-1:0] fidx_in,
  output pfd_tok_t         tok_out,
  output logic [IDX_W-1:0] fidx_out
);

  logic             valid_r, valid_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [7:0]       level_r, level_nxt;
  logic [31:0]      stamp_r, stamp_nxt;
  pfd_tok_t         tok_r, tok_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  logic [31:0]      gap;
  logic             match;
  logic [7:0]       lvl;
  logic             flood;

  assign gap   = tok_in.now - stamp_r;
  assign match = valid_r && (key_r == tok_in.key);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    level_nxt = level_r;
    stamp_nxt = stamp_r;
    tok_nxt   = tok_in;
    fidx_nxt  = fidx_in;
    lvl       = level_r;
    flood     = 1'b0;
    if (tok_in.vld) begin
      case (tok_in.req)
        REQ_MSG: begin
          if (match && !tok_in.hit) begin
            if (gap <= {24'd0, cfg.burst}) begin
              if (level_r == cfg.trigger) begin
                flood = 1'b1;
                if (level_r != 8'd0) begin
                  lvl = level_r - 8'd1;
                end
              end else if (level_r != LEVEL_MAX) begin
                lvl = level_r + 8'd1;
              end
            end
            level_nxt     = lvl;
            stamp_nxt     = tok_in.now;
            tok_nxt.hit   = 1'b1;
            tok_nxt.flood = flood;
            tok_nxt.level = lvl;
          end else if (!valid_r && !tok_in.free_seen) begin
            tok_nxt.free_seen = 1'b1;
            fidx_nxt          = slot_idx;
          end
        end
        REQ_SWEEP: begin
          if (valid_r && (gap > {24'd0, cfg.idle})) begin
            if (level_r == 8'd0) begin
              valid_nxt = 1'b0;
            end else begin
              level_nxt = level_r - 8'd1;
            end
          end
        end
        REQ_REMOVE: begin
          if (match) begin
            valid_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (ins.en && (ins_idx == slot_idx)) begin
      valid_nxt = 1'b1;
      key_nxt   = ins.key;
      level_nxt = 8'd0;
      stamp_nxt = ins.now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
    key_r   <= key_nxt;
    level_r <= level_nxt;
    stamp_r <= stamp_nxt;
    fidx_r  <= fidx_nxt;
  end

  assign tok_out  = tok_r;
  assign fidx_out = fidx_r;

endmodule

>>> rtl/per_source_flood_detector.sv
// top level: request launch, cell chain, insertion and result register
// one item in flight: input is stalled from each transfer until its result is registered
// steps: the launch register, the chain walk, collecting the token, then registering the
//   result and inserting (held while the result output is stalled), then the next transfer
// reset: synchronous, active low; clears all entry valid bits at once and
//   loads trigger 5, burst window 1 s and idle age 3 s
module per_source_flood_detector
  import pfd_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_source_id,
  input  logic [31:0] in_now_sec,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_flooded,
  output logic        out_status,
  output logic [7:0]  out_level_after
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  pfd_cfg_t         cfg_r, cfg_nxt;
  pfd_tok_t         launch_r, launch_nxt;
  pfd_tok_t         fin_r, fin_nxt;
  logic [IDX_W-1:0] fin_idx_r, fin_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_flooded_r, out_flooded_nxt;
  logic             out_status_r, out_status_nxt;
  logic [7:0]       out_level_r, out_level_nxt;
  pfd_ins_t         ins;
  logic             accept;
  logic             out_free;
  logic             fin_msg;

  pfd_tok_t         tok  [TABLE_ENTRIES+1];
  logic [IDX_W-1:0] fidx [TABLE_ENTRIES+1];

  assign tok[0]  = launch_r;
  assign fidx[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    pfd_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .slot_idx (IDX_W'(i)),
      .cfg      (cfg_r),
      .ins      (ins),
      .ins_idx  (fin_idx_r),
      .tok_in   (tok[i]),
      .fidx_in  (fidx[i]),
      .tok_out  (tok[i+1]),
      .fidx_out (fidx[i+1])
    );
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign fin_msg  = (fin_r.req == REQ_MSG);

  assign ins.en  = (state_r == ST_DONE) && out_free && fin_msg && !fin_r.hit
                   && fin_r.free_seen;
  assign ins.key = fin_r.key;
  assign ins.now = fin_r.now;

  always_comb begin
    state_nxt       = state_r;
    cfg_nxt         = cfg_r;
    launch_nxt      = launch_r;
    fin_nxt         = fin_r;
    fin_idx_nxt     = fin_idx_r;
    out_valid_nxt   = out_valid_r;
    out_flooded_nxt = out_flooded_r;
    out_status_nxt  = out_status_r;
    out_level_nxt   = out_level_r;

    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TRIGGER: cfg_nxt.trigger = cfg_wdata;
        CFG_BURST:   cfg_nxt.burst   = cfg_wdata;
        CFG_IDLE:    cfg_nxt.idle    = cfg_wdata;
        default: begin
        end
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    launch_nxt.vld = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          launch_nxt.vld       = 1'b1;
          launch_nxt.req       = in_req_type;
          launch_nxt.key       = in_source_id;
          launch_nxt.now       = in_now_sec;
          launch_nxt.hit       = 1'b0;
          launch_nxt.free_seen = 1'b0;
          launch_nxt.flood     = 1'b0;
          launch_nxt.level     = 8'd0;
          state_nxt            = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tok[TABLE_ENTRIES].vld) begin
          fin_nxt     = tok[TABLE_ENTRIES];
          fin_idx_nxt = fidx[TABLE_ENTRIES];
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_flooded_nxt = fin_msg && fin_r.hit && fin_r.flood;
          out_status_nxt  = fin_msg && !fin_r.hit && !fin_r.free_seen;
          out_level_nxt   = (fin_msg && fin_r.hit) ? fin_r.level : 8'd0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cfg_r.trigger <= TRIGGER_RST;
      cfg_r.burst   <= BURST_RST;
      cfg_r.idle    <= IDLE_RST;
      launch_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fin_r         <= fin_nxt;
    fin_idx_r     <= fin_idx_nxt;
    out_flooded_r <= out_flooded_nxt;
    out_status_r  <= out_status_nxt;
    out_level_r   <= out_level_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_flooded     = out_flooded_r;
  assign out_status      = out_status_r;
  assign out_level_after = out_level_r;

endmodule

>>> rtl/pfd_checker.sv
// port-level checks for the flood detector, bound to the top level
module pfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_flooded,
  input logic        out_status,
  input logic [7:0]  out_level_after
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_flooded) && $stable(out_status)
      && $stable(out_level_after))
    else $error("result payload changed while stalled");

  // one item in flight: input is held off after every transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // a full-table result never carries a flood flag
  a_full_no_flood: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_flooded && out_status))
    else $error("flood and table full flagged together");

  // an untracked source reports level zero
  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_level_after == 8'd0)
    else $error("table full result with non-zero level");

endmodule

bind per_source_flood_detector pfd_checker u_pfd_checker (.*);

>>> verif/tb_top.sv
// self-checking bench for per_source_flood_detector: directed and random traffic against a table model
`timescale 1ns / 1ps

module tb_top;
  import pfd_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int LATENCY       = TABLE_ENTRIES + 3;
  localparam int CYCLE_LIMIT   = 2_500_000;

  typedef struct packed {
    logic       flooded;
    logic       status;
    logic [7:0] level;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_TRIGGER;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_NOP;
  logic [31:0] in_source_id = 32'd0;
  logic [31:0] in_now_sec = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_flooded;
  logic        out_status;
  logic [7:0]  out_level_after;

  // model of the source table and registers
  logic        tbl_used  [TABLE_ENTRIES];
  logic [31:0] tbl_key   [TABLE_ENTRIES];
  logic [7:0]  tbl_level [TABLE_ENTRIES];
  logic [31:0] tbl_stamp [TABLE_ENTRIES];
  logic [7:0]  trig_q  = TRIGGER_RST;
  logic [7:0]  burst_q = BURST_RST;
  logic [7:0]  idle_q  = IDLE_RST;

  verdict_t    pending_verdicts[$];
  logic [31:0] wall_sec = 32'd0;
  logic        calm = 1'b0;
  int          hold_request = 0;
  int          cycle_count = 0;
  int          bad_results = 0;
  int          results_checked = 0;
  int          items_sent = 0;
  int          floods_predicted = 0;
  int          full_predicted = 0;
  int          settings_used = 0;

  per_source_flood_detector #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_source_id    (in_source_id),
    .in_now_sec      (in_now_sec),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_flooded     (out_flooded),
    .out_status      (out_status),
    .out_level_after (out_level_after)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_verdicts.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic verdict_t flood_verdict(input logic [1:0] req, input logic [31:0] src,
                                             input logic [31:0] now);
    verdict_t    v;
    int          hit;
    int          slot;
    logic [31:0] gap;
    logic [7:0]  lvl;
    v = '0;
    hit = -1;
    slot = -1;
    case (req)
      REQ_MSG: begin
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
          if (tbl_used[i] && tbl_key[i] == src) hit = i;
          if (!tbl_used[i]) slot = i;
        end
        if (hit < 0) begin
          if (slot < 0) begin
            v.status = 1'b1;
          end else begin
            tbl_used[slot]  = 1'b1;
            tbl_key[slot]   = src;
            tbl_level[slot] = 8'd0;
            tbl_stamp[slot] = now;
          end
        end else begin
          gap = now - tbl_stamp[hit];
          lvl = tbl_level[hit];
          if (gap <= {24'd0, burst_q}) begin
            if (lvl == trig_q) begin
              v.flooded = 1'b1;
              if (lvl != 8'd0) lvl = lvl - 8'd1;
            end else if (lvl != LEVEL_MAX) begin
              lvl = lvl + 8'd1;
            end
          end
          tbl_level[hit] = lvl;
          tbl_stamp[hit] = now;
          v.level = lvl;
        end
      end
      REQ_SWEEP: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (tbl_used[i] && (now - tbl_stamp[i]) > {24'd0, idle_q}) begin
            if (tbl_level[i] == 8'd0) tbl_used[i] = 1'b0;
            else tbl_level[i] = tbl_level[i] - 8'd1;
          end
        end
      end
      REQ_REMOVE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (tbl_used[i] && tbl_key[i] == src) tbl_used[i] = 1'b0;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_step();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(0, burst_q);
    if (r < 90) return burst_q + $urandom_range(1, 3);
    if (r < 97) return $urandom_range(0, 2000);
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_reg_value(input int small_max);
    int r;
    r = $urandom_range(99);
    if (r < 60) return 8'($urandom_range(0, small_max));
    if (r < 80) return (r < 70) ? 8'd0 : LEVEL_MAX;
    return 8'($urandom_range(0, 255));
  endfunction

  // result side: random stalls, calm runs, and long hold-offs on request
  initial begin : result_stall
    int n;
    int r;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_stall <= 1'b1;
        n = hold_request;
        hold_request = 0;
      end else if (calm) begin
        out_stall <= 1'b0;
        n = 1;
      end else begin
        r = $urandom_range(99);
        if (r < 55) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 30);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 4);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(20, 160);
        end
      end
      repeat (n - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        if (bad_results < 10)
          $display("unexpected result: flooded %0b status %0b level %0d",
                   out_flooded, out_status, out_level_after);
        bad_results++;
      end else begin
        want = pending_verdicts.pop_front();
        results_checked++;
        if (out_flooded !== want.flooded || out_status !== want.status ||
            out_level_after !== want.level) begin
          if (bad_results < 10)
            $display("result %0d: expected flooded %0b status %0b level %0d, got %0b %0b %0d",
                     results_checked, want.flooded, want.status, want.level,
                     out_flooded, out_status, out_level_after);
          bad_results++;
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] req, input logic [31:0] src,
                           input logic [31:0] now);
    int       gap;
    verdict_t v;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_source_id <= src;
    in_now_sec   <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = flood_verdict(req, src, now);
    pending_verdicts.push_back(v);
    items_sent++;
    if (v.flooded) floods_predicted++;
    if (v.status) full_predicted++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] trig, input logic [7:0] burst,
                            input logic [7:0] idle);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_TRIGGER;
    cfg_wdata <= trig;
    @(posedge clk);
    cfg_addr  <= CFG_BURST;
    cfg_wdata <= burst;
    @(posedge clk);
    cfg_addr  <= CFG_IDLE;
    cfg_wdata <= idle;
    @(posedge clk);
    cfg_we <= 1'b0;
    trig_q  = trig;
    burst_q = burst;
    idle_q  = idle;
    settings_used++;
  endtask

  task automatic run_traffic(input int n_items, input int pool);
    logic [31:0] keys[$];
    logic [31:0] src;
    int          r;
    keys.delete();
    repeat (pool) keys.push_back($urandom);
    repeat (n_items) begin
      r = $urandom_range(99);
      src = keys[$urandom_range(pool - 1)];
      if (r < 78) begin
        wall_sec = wall_sec + pick_step();
        send_item(REQ_MSG, src, wall_sec);
      end else if (r < 87) begin
        wall_sec = wall_sec + $urandom_range(0, 2 * idle_q + 2);
        send_item(REQ_SWEEP, $urandom, wall_sec);
      end else if (r < 93) begin
        send_item(REQ_REMOVE, (r < 91) ? src : $urandom, wall_sec);
      end else if (r < 96) begin
        send_item(REQ_NOP, $urandom, $urandom);
      end else begin
        send_item(2'($urandom_range(3)), $urandom, $urandom);
      end
    end
  endtask

  task automatic test_directed_defaults();
    send_item(REQ_MSG, 32'h0000_0000, 32'hFFFF_FFFE);
    send_item(REQ_MSG, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(REQ_MSG, 32'h0000_0000, 32'h0000_0000);
    send_item(REQ_MSG, 32'h0000_0000, 32'h0000_0000);
    send_item(REQ_MSG, 32'h0000_0000, 32'h0000_0001);
    send_item(REQ_MSG, 32'h0000_0000, 32'h0000_0002);
    send_item(REQ_MSG, 32'h0000_0000, 32'h0000_0002);
    send_item(REQ_MSG, 32'h0000_0000, 32'h0000_000A);
    send_item(REQ_MSG, 32'hFFFF_FFFF, 32'h0000_000A);
    send_item(REQ_MSG, 32'hFFFF_FFFF, 32'h0000_000B);
    send_item(REQ_REMOVE, 32'h1234_5678, 32'h0000_000B);
    send_item(REQ_SWEEP, 32'h0000_0000, 32'h0000_000D);
    send_item(REQ_SWEEP, 32'h0000_0000, 32'h0000_000E);
    send_item(REQ_SWEEP, 32'h0000_0000, 32'h0000_000F);
    send_item(REQ_MSG, 32'hFFFF_FFFF, 32'h0000_000F);
    send_item(REQ_REMOVE, 32'h0000_0000, 32'h0000_0010);
    send_item(REQ_MSG, 32'h5A5A_A5A5, 32'h0000_0010);
    send_item(REQ_MSG, 32'h0000_0000, 32'h0000_0010);
    send_item(REQ_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(REQ_NOP, 32'h0000_0000, 32'h0000_0000);
    send_item(REQ_SWEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wall_sec = 32'h0000_0020;
  endtask

  task automatic test_level_saturation();
    logic [31:0] src;
    src = $urandom;
    wait_drained();
    set_config(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
    calm = 1'b1;
    repeat (258) send_item(REQ_MSG, src, wall_sec);
    wait_drained();
    set_config(8'd7, LEVEL_MAX, 8'd0);
    send_item(REQ_MSG, src, wall_sec);
    send_item(REQ_SWEEP, $urandom, wall_sec + 32'd1);
    send_item(REQ_MSG, src, wall_sec + 32'd1);
    send_item(REQ_REMOVE, src, wall_sec + 32'd1);
    wall_sec = wall_sec + 32'd1;
    calm = 1'b0;
  endtask

  task automatic test_table_full();
    wait_drained();
    set_config(TRIGGER_RST, BURST_RST, 8'd0);
    wall_sec = wall_sec + 32'd1000;
    repeat (TABLE_ENTRIES + 6) send_item(REQ_MSG, $urandom, wall_sec);
    send_item(REQ_SWEEP, $urandom, wall_sec + 32'd1);
    repeat (4) send_item(REQ_MSG, $urandom, wall_sec + 32'd2);
    wall_sec = wall_sec + 32'd2;
  endtask

  task automatic test_config_extremes();
    for (int i = 0; i < 6; i++) begin
      wait_drained();
      case (i)
        0: set_config(8'd1, 8'd0, 8'd0);
        1: set_config(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        2: set_config(8'd0, 8'd1, 8'd3);
        3: set_config(8'd0, 8'd0, LEVEL_MAX);
        4: set_config(8'd2, LEVEL_MAX, 8'd0);
        default: set_config(8'd1, 8'd3, 8'd8);
      endcase
      run_traffic(55, 6);
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    set_config(8'd3, 8'd2, 8'd5);
    calm = 1'b1;
    hold_request = 600;
    while (hold_request != 0) @(posedge clk);
    run_traffic(12, 3);
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int pool;
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      set_config(pick_reg_value(6), pick_reg_value(4), pick_reg_value(8));
      calm = (p == 3);
      wall_sec = (p == 1) ? 32'hFFFF_FF80 : $urandom;
      case (p % 4)
        0: pool = 3;
        1: pool = 12;
        2: pool = 45;
        default: pool = 90;
      endcase
      run_traffic(150, pool);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_defaults();
    test_level_saturation();
    test_table_full();
    test_config_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d transfers in (messages, sweeps, removes, idle codes) over %0d settings",
             items_sent, settings_used + 1);
    $display("checked %0d results, %0d flood flags and %0d table-full replies among them",
             results_checked, floods_predicted, full_predicted);
    if (bad_results == 0 && pending_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d bad results, %0d outstanding", bad_results, pending_verdicts.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
